@@ rtl/boot_sector_byte_scanner_macros.svh @@
// ----------------------------------------------------------------------------
// Boot sector byte scanner assertion macros
// Shared wrappers for the concurrent checks of the scanner.
// ----------------------------------------------------------------------------
`ifndef BOOT_SECTOR_BYTE_SCANNER_MACROS_SVH
`define BOOT_SECTOR_BYTE_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bss_pkg.sv @@
// ----------------------------------------------------------------------------
// Boot sector byte scanner package
// Sizes, byte codes, register indexes and helper functions of the scanner.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int CHUNK_LEN    = 4;
  localparam int MARKER_LEN   = 6;

  localparam int POS_W   = $clog2(SECTOR_BYTES);
  localparam int CHUNK_W = $clog2(CHUNK_LEN);
  localparam int WIN_DEPTH = MARKER_LEN - 1;

  localparam int OPC_W   = 9;
  localparam int TEXT_W  = 7;
  localparam int NZ_W    = 10;
  localparam int THR_W   = 9;
  localparam int FLOOR_W = 10;
  localparam int PAT_W   = 48;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  localparam logic [15:0] BOOT_MAGIC = 16'hAA55;
  localparam logic [7:0]  JMP_SHORT  = 8'hEB;
  localparam logic [7:0]  JMP_NEAR   = 8'hE9;
  localparam logic [7:0]  OP_CLI     = 8'hFA;
  localparam logic [7:0]  OP_STI     = 8'hFB;
  localparam logic [7:0]  OP_INT     = 8'hCD;
  localparam logic [7:0]  OP_CALL    = 8'hE8;
  localparam logic [7:0]  PRINT_LO   = 8'd32;
  localparam logic [7:0]  PRINT_HI   = 8'd126;

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(5);
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(52);

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_FLOOR     = 2'd1,
    REG_MARKER    = 2'd2
  } bss_reg_t;

  // Control handed from the sequencer to the marker matcher.
  typedef struct packed {
    logic step;       // a byte is consumed this cycle
    logic head_done;  // a whole marker window lies inside the sector
  } bss_step_t;

  function automatic logic is_opcode(input logic [7:0] b);
    return (b == OP_CLI) || (b == OP_STI) || (b == OP_INT) || (b == OP_CALL);
  endfunction

  function automatic logic is_print(input logic [7:0] b);
    return (b >= PRINT_LO) && (b <= PRINT_HI);
  endfunction

  function automatic logic is_jump(input logic [7:0] b);
    return (b == JMP_SHORT) || (b == JMP_NEAR);
  endfunction

  // Marker byte k, taken modulo 8; bytes 6 and 7 lie beyond the register and read as zero.
  function automatic logic [7:0] marker_byte(input logic [PAT_W-1:0] pat, input int k);
    logic [63:0] wide;
    wide = {{(64-PAT_W){1'b0}}, pat};
    return wide[8*(k%8) +: 8];
  endfunction

endpackage

@@ rtl/bss_marker_match.sv @@
// ----------------------------------------------------------------------------
// Boot sector byte scanner marker matcher
// Keeps the last bytes of the sector and compares them with the marker.
// ----------------------------------------------------------------------------
module bss_marker_match (
  input  logic                        clk,
  input  bss_pkg::bss_step_t          ctl,
  input  logic [7:0]                  data_byte,
  input  logic [bss_pkg::PAT_W-1:0]   pattern,
  output logic                        match
);

  // win_r[0] holds the previous byte, win_r[i] the byte i+1 places back.
  logic [7:0] win_r [bss_pkg::WIN_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      win_r[0] <= data_byte;
      for (int i = 1; i < bss_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  always_comb begin
    logic hit;
    hit = (data_byte == bss_pkg::marker_byte(pattern, bss_pkg::MARKER_LEN - 1));
    for (int i = 0; i < bss_pkg::WIN_DEPTH; i++) begin
      if (win_r[i] != bss_pkg::marker_byte(pattern, bss_pkg::MARKER_LEN - 2 - i)) begin
        hit = 1'b0;
      end
    end
    match = hit && ctl.head_done;
  end

endmodule

@@ rtl/boot_sector_byte_scanner.sv @@
// ----------------------------------------------------------------------------
// Boot sector byte scanner
// Scans one sector byte by byte and reports a verdict on its last byte.
// ----------------------------------------------------------------------------
// The in_ channel carries one sector byte per item, in offset order. Every
// item is first captured in an input register; when it moves on, the
// scanner updates its tallies from that byte. Only the last byte of a sector
// yields an item on the out_ channel, carrying the whole verdict in out_tdata.
// Throughput is one byte per cycle, but for a last byte that stalls. The
// verdict goes into a result register that drives out_tvalid, and is held
// there until the receiver takes it. While that result waits, bytes that are not
// the last of a sector keep flowing; only the next last byte stalls in the
// input register until the result register is free. The ready path runs
// from out_tready through that decision to in_tready.
// After each verdict all per-sector state clears, so the following byte is
// offset zero of a new sector. Reset clears the tallies, drops any pending
// item and restores the register defaults (threshold 5, density floor 52,
// marker zero). The configuration registers sit on an APB port at byte
// addresses 0, 8 and 16 and are meant to be written while the scanner idles.
// ----------------------------------------------------------------------------
`include "boot_sector_byte_scanner_macros.svh"

module boot_sector_byte_scanner (
  input  logic                         clk,
  input  logic                         rst_n,
  // Sector byte stream.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] data_byte
  // Verdict stream.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [0] signature_ok, [16:1] signature_value, [24:17] first_value,
  // [25] jump_at_start, [26] marker_found, [35:27] opcode_count,
  // [36] opcode_plenty, [43:37] text_chunks, [53:44] nonzero_count,
  // [54] low_density, [55] zero fill
  output logic [55:0]                  out_tdata,
  // Configuration port.
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [bss_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [bss_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [bss_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  localparam logic [bss_pkg::POS_W-1:0] LAST_POS =
    bss_pkg::POS_W'(bss_pkg::SECTOR_BYTES - 1);
  localparam logic [bss_pkg::POS_W-1:0] SIG_LO_POS =
    bss_pkg::POS_W'(bss_pkg::SECTOR_BYTES - 2);
  localparam logic [bss_pkg::POS_W-1:0] HEAD_POS =
    bss_pkg::POS_W'(bss_pkg::MARKER_LEN - 1);
  localparam logic [bss_pkg::CHUNK_W-1:0] CHUNK_END =
    bss_pkg::CHUNK_W'(bss_pkg::CHUNK_LEN - 1);

  // Configuration registers.
  logic [bss_pkg::THR_W-1:0]   thr_r;
  logic [bss_pkg::FLOOR_W-1:0] floor_r;
  logic [bss_pkg::PAT_W-1:0]   pattern_r;
  bss_pkg::bss_reg_t           cfg_reg;
  logic                        cfg_write;

  assign cfg_pready = 1'b1;
  assign cfg_reg    = bss_pkg::bss_reg_t'(cfg_paddr[bss_pkg::CFG_AW-1:3]);
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= bss_pkg::THR_RESET;
      floor_r   <= bss_pkg::FLOOR_RESET;
      pattern_r <= '0;
    end else if (cfg_write) begin
      case (cfg_reg)
        bss_pkg::REG_THRESHOLD: thr_r     <= cfg_pwdata[bss_pkg::THR_W-1:0];
        bss_pkg::REG_FLOOR:     floor_r   <= cfg_pwdata[bss_pkg::FLOOR_W-1:0];
        bss_pkg::REG_MARKER:    pattern_r <= cfg_pwdata[bss_pkg::PAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      bss_pkg::REG_THRESHOLD: cfg_prdata = bss_pkg::CFG_DW'(thr_r);
      bss_pkg::REG_FLOOR:     cfg_prdata = bss_pkg::CFG_DW'(floor_r);
      bss_pkg::REG_MARKER:    cfg_prdata = bss_pkg::CFG_DW'(pattern_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last;
  logic       s1_advance;

  // Per-sector state.
  logic [bss_pkg::POS_W-1:0]   pos_r;
  logic [7:0]                  first_r;
  logic [7:0]                  sig_lo_r;
  logic                        marker_seen_r;
  logic [bss_pkg::OPC_W-1:0]   opc_r;
  logic [bss_pkg::CHUNK_W-1:0] chunk_prog_r;
  logic [bss_pkg::TEXT_W-1:0]  text_r;
  logic [bss_pkg::NZ_W-1:0]    nz_r;

  // Result register.
  logic        out_valid_r;
  logic [55:0] out_data_r;

  logic                       match;
  bss_pkg::bss_step_t         step_ctl;
  logic [bss_pkg::NZ_W-1:0]   nz_upd;
  logic [bss_pkg::OPC_W-1:0]  opc_upd;
  logic [bss_pkg::TEXT_W-1:0] text_upd;
  logic [bss_pkg::CHUNK_W-1:0] chunk_prog_upd;
  logic                       marker_upd;
  logic [15:0]                sig;
  logic [55:0]                verdict;

  // A byte that ends the sector needs a free result register; any other
  // byte moves on at once.
  assign s1_last    = (pos_r == LAST_POS);
  assign s1_advance = s1_valid_r && (!s1_last || !out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  assign step_ctl.step      = s1_advance;
  assign step_ctl.head_done = (pos_r >= HEAD_POS);

  bss_marker_match u_marker (
    .clk       (clk),
    .ctl       (step_ctl),
    .data_byte (s1_byte_r),
    .pattern   (pattern_r),
    .match     (match)
  );

  // Tally updates for the byte in the input register.
  always_comb begin
    nz_upd = nz_r;
    if ((s1_byte_r != 8'd0) && (nz_r != '1)) begin
      nz_upd = nz_r + 1'b1;
    end

    // The last byte of the sector never counts as an opcode.
    opc_upd = opc_r;
    if (!s1_last && bss_pkg::is_opcode(s1_byte_r) && (opc_r != '1)) begin
      opc_upd = opc_r + 1'b1;
    end

    // Greedy chunks: a printable run restarts once it reaches full length.
    text_upd       = text_r;
    chunk_prog_upd = '0;
    if (bss_pkg::is_print(s1_byte_r)) begin
      if (chunk_prog_r == CHUNK_END) begin
        if ((pos_r <= SIG_LO_POS) && (text_r != '1)) begin
          text_upd = text_r + 1'b1;
        end
      end else begin
        chunk_prog_upd = chunk_prog_r + 1'b1;
      end
    end

    marker_upd = marker_seen_r || match;
    sig        = {s1_byte_r, sig_lo_r};

    verdict = {1'b0,
               (nz_upd < floor_r),
               nz_upd,
               text_upd,
               (opc_upd > thr_r),
               opc_upd,
               marker_upd,
               bss_pkg::is_jump(first_r),
               first_r,
               sig,
               (sig == bss_pkg::BOOT_MAGIC)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      marker_seen_r <= 1'b0;
      opc_r         <= '0;
      chunk_prog_r  <= '0;
      text_r        <= '0;
      nz_r          <= '0;
    end else if (s1_advance) begin
      if (s1_last) begin
        pos_r         <= '0;
        marker_seen_r <= 1'b0;
        opc_r         <= '0;
        chunk_prog_r  <= '0;
        text_r        <= '0;
        nz_r          <= '0;
      end else begin
        pos_r         <= pos_r + 1'b1;
        marker_seen_r <= marker_upd;
        opc_r         <= opc_upd;
        chunk_prog_r  <= chunk_prog_upd;
        text_r        <= text_upd;
        nz_r          <= nz_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && (pos_r == '0)) begin
      first_r <= s1_byte_r;
    end
    if (s1_advance && (pos_r == SIG_LO_POS)) begin
      sig_lo_r <= s1_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && s1_last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last) begin
      out_data_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A last byte must never overwrite a verdict the receiver has not taken.
  `BSS_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && !out_tready && s1_last, !s1_advance, "verdict overwritten while stalled")
  // Finishing a sector returns the position to offset zero.
  `BSS_ASSERT_NEXT(a_sector_wraps, clk, rst_n, s1_advance && s1_last, pos_r == '0 && out_valid_r, "sector did not wrap after verdict")
  // Tallies never run ahead of the number of bytes seen.
  `BSS_ASSERT_NOW(a_tally_bound, clk, rst_n, 1'b1, (bss_pkg::POS_W'(opc_r) <= pos_r) && (bss_pkg::NZ_W'(pos_r) >= nz_r), "tally exceeds byte position")

endmodule
